// ===== rtl/nmea_sentence_field_extractor_assert.svh =====
// Assertion macros shared by the sentence field extractor RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef NMEA_SENTENCE_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_SENTENCE_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NSFE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NSFE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nsfe_pkg.sv =====
// Shared types and constants of the sentence field extractor.
// No dependencies; used by nsfe_parser and the top level.
package nsfe_pkg;

  // Framing characters.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Header counter value once the body of a sentence is reached.
  localparam logic [2:0] HDR_BODY = 3'd6;

  // Reset values of the type code registers.
  localparam logic [31:0] TYPE_CODE_A_RST = 32'h434D_524E;
  localparam logic [31:0] TYPE_CODE_B_RST = 32'h4147_474E;
  localparam logic [31:0] TYPE_CODE_C_RST = 32'h5653_4750;

  // Default bounds.
  localparam int unsigned MAX_FIELDS_DEF      = 32;
  localparam int unsigned MAX_FIELD_CHARS_DEF = 16;

  // Sentence type codes.
  localparam logic [1:0] SENT_A = 2'd0;
  localparam logic [1:0] SENT_B = 2'd1;
  localparam logic [1:0] SENT_C = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TYPE_A = 2'd0,
    CFG_TYPE_B = 2'd1,
    CFG_TYPE_C = 2'd2
  } cfg_reg_e;

  // Kind of result item.
  typedef enum logic [1:0] {
    EV_CHAR    = 2'd0,
    EV_FIELD   = 2'd1,
    EV_VERDICT = 2'd2
  } event_kind_e;

  // One result item.
  typedef struct packed {
    event_kind_e event_kind;
    logic [1:0]  sentence_type;
    logic [4:0]  field_index;
    logic [3:0]  char_index;
    logic [7:0]  char_value;
    logic        checksum_ok;
  } result_t;

endpackage

// ===== rtl/nsfe_parser.sv =====
// Sentence parser state and per-byte decode of the field extractor.
// Depends on nsfe_pkg and nmea_sentence_field_extractor_assert.svh.
`include "nmea_sentence_field_extractor_assert.svh"

module nsfe_parser #(
  parameter int unsigned MAX_FIELDS      = nsfe_pkg::MAX_FIELDS_DEF,
  parameter int unsigned MAX_FIELD_CHARS = nsfe_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       type_code_a_i,
  input  logic [31:0]       type_code_b_i,
  input  logic [31:0]       type_code_c_i,
  output logic              res_valid_o,
  output nsfe_pkg::result_t res_o
);

  localparam int unsigned FNW = $clog2(MAX_FIELDS + 1);
  localparam int unsigned CPW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [FNW-1:0] FN_MAX = FNW'(MAX_FIELDS);
  localparam logic [CPW-1:0] CP_MAX = CPW'(MAX_FIELD_CHARS);

  logic           active_q, active_d;
  logic [2:0]     hc_q, hc_d;
  logic [31:0]    hw_q, hw_d;
  logic [1:0]     mk_q, mk_d;
  logic           open_q, open_d;
  logic [FNW-1:0] fn_q, fn_d;
  logic [CPW-1:0] cp_q, cp_d;
  logic           inck_q, inck_d;
  logic [7:0]     xor_q, xor_d;
  logic [7:0]     hex0_q, hex0_d;
  logic           hcc_q, hcc_d;

  logic              emit;
  nsfe_pkg::event_kind_e emit_kind;
  logic [FNW-1:0]    emit_fn;
  logic [CPW-1:0]    emit_cp;
  logic [7:0]        emit_ch;
  logic              emit_ok;
  logic [2:0]        hc_n;
  logic [7:0]        hex_hi;
  logic [7:0]        hex_sum;
  logic [FNW+4:0]    fn_ext;
  logic [CPW+3:0]    cp_ext;

  // Value of one checksum digit; anything that is not 0-9 or A-F keeps its byte value.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c;
    end
    return v;
  endfunction

  assign hc_n    = (hc_q < nsfe_pkg::HDR_BODY) ? hc_q + 3'd1 : hc_q;
  assign hex_hi  = hex_value(hex0_q);
  assign hex_sum = {hex_hi[3:0], 4'h0} + hex_value(rx_byte_i);

  // Next state and result for the byte in the input register.
  always_comb begin
    active_d  = active_q;
    hc_d      = hc_q;
    hw_d      = hw_q;
    mk_d      = mk_q;
    open_d    = open_q;
    fn_d      = fn_q;
    cp_d      = cp_q;
    inck_d    = inck_q;
    xor_d     = xor_q;
    hex0_d    = hex0_q;
    hcc_d     = hcc_q;
    emit      = 1'b0;
    emit_kind = nsfe_pkg::EV_CHAR;
    emit_fn   = '0;
    emit_cp   = '0;
    emit_ch   = '0;
    emit_ok   = 1'b0;

    if (rx_byte_i == nsfe_pkg::CH_DOLLAR) begin
      // A dollar restarts the sentence from any state.
      active_d = 1'b1;
      hc_d     = '0;
      hw_d     = '0;
      mk_d     = nsfe_pkg::SENT_A;
      open_d   = 1'b0;
      fn_d     = '0;
      cp_d     = '0;
      inck_d   = 1'b0;
      hcc_d    = 1'b0;
    end else if (active_q) begin
      hc_d = hc_n;
      if (hc_n <= 3'd1) begin
        // First character seeds the checksum.
        xor_d = rx_byte_i;
      end else if (rx_byte_i == nsfe_pkg::CH_STAR) begin
        hw_d   = '0;
        inck_d = 1'b1;
        hcc_d  = 1'b0;
      end else begin
        if (!inck_q) begin
          xor_d = xor_q ^ rx_byte_i;
        end
        if (hc_n < nsfe_pkg::HDR_BODY) begin
          // Header characters, first one in the low byte.
          unique case (hc_n)
            3'd2:    hw_d[7:0]   = rx_byte_i;
            3'd3:    hw_d[15:8]  = rx_byte_i;
            3'd4:    hw_d[23:16] = rx_byte_i;
            default: hw_d[31:24] = rx_byte_i;
          endcase
        end else if (inck_q) begin
          // Two checksum digits, then the verdict.
          if (!hcc_q) begin
            hex0_d = rx_byte_i;
            hcc_d  = 1'b1;
          end else begin
            inck_d    = 1'b0;
            hcc_d     = 1'b0;
            active_d  = 1'b0;
            emit      = 1'b1;
            emit_kind = nsfe_pkg::EV_VERDICT;
            emit_ok   = (hex_sum == xor_q);
          end
        end else begin
          // Body byte: check the type first.
          priority if (hw_q == type_code_a_i) begin
            mk_d = nsfe_pkg::SENT_A;
          end else if (hw_q == type_code_b_i) begin
            mk_d = nsfe_pkg::SENT_B;
          end else if (hw_q == type_code_c_i) begin
            mk_d = nsfe_pkg::SENT_C;
          end else begin
            active_d = 1'b0;
          end
          if (active_d) begin
            if (rx_byte_i == nsfe_pkg::CH_COMMA) begin
              cp_d = '0;
              if (!open_q) begin
                open_d = 1'b1;
                fn_d   = '0;
              end else if (fn_q < FN_MAX) begin
                fn_d = fn_q + 1'b1;
              end
              if (fn_d < FN_MAX) begin
                emit      = 1'b1;
                emit_kind = nsfe_pkg::EV_FIELD;
                emit_fn   = fn_d;
              end
            end else if (open_q && fn_q < FN_MAX && cp_q < CP_MAX) begin
              emit      = 1'b1;
              emit_kind = nsfe_pkg::EV_CHAR;
              emit_fn   = fn_q;
              emit_cp   = cp_q;
              emit_ch   = rx_byte_i;
              cp_d      = cp_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // Indices are reported at their port widths.
  assign fn_ext = (FNW + 5)'(emit_fn);
  assign cp_ext = (CPW + 4)'(emit_cp);

  assign res_valid_o          = emit;
  assign res_o.event_kind     = emit_kind;
  assign res_o.sentence_type  = mk_d;
  assign res_o.field_index    = fn_ext[4:0];
  assign res_o.char_index     = cp_ext[3:0];
  assign res_o.char_value     = emit_ch;
  assign res_o.checksum_ok    = emit_ok;

  // Parser control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hc_q     <= '0;
      hw_q     <= '0;
      mk_q     <= nsfe_pkg::SENT_A;
      open_q   <= 1'b0;
      fn_q     <= '0;
      cp_q     <= '0;
      inck_q   <= 1'b0;
      xor_q    <= '0;
      hcc_q    <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      hc_q     <= hc_d;
      hw_q     <= hw_d;
      mk_q     <= mk_d;
      open_q   <= open_d;
      fn_q     <= fn_d;
      cp_q     <= cp_d;
      inck_q   <= inck_d;
      xor_q    <= xor_d;
      hcc_q    <= hcc_d;
    end
  end

  // First checksum digit is always captured before it is used.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hex0_q <= hex0_d;
    end
  end

  // A dollar leaves the header counter and checksum mode cleared.
  `NSFE_ASSERT_NXT(a_dollar_restart, clk_i, rst_ni,
    step_i && rx_byte_i == nsfe_pkg::CH_DOLLAR,
    active_q && hc_q == 3'd0 && !inck_q, "dollar did not restart the sentence")
  // A verdict ends the sentence.
  `NSFE_ASSERT_NXT(a_verdict_idle, clk_i, rst_ni,
    step_i && res_valid_o && res_o.event_kind == nsfe_pkg::EV_VERDICT,
    !active_q, "sentence still active after the checksum verdict")
  // Results come only from an active sentence, characters only from an open field.
  `NSFE_ASSERT_IMP(a_res_active, clk_i, rst_ni, res_valid_o,
    active_q && (res_o.event_kind != nsfe_pkg::EV_CHAR || open_q),
    "result produced outside an open sentence")

endmodule

// ===== rtl/nmea_sentence_field_extractor.sv =====
// Top level of the sentence field extractor: stream ports, type code registers,
// input and result registers. Depends on nsfe_pkg and nsfe_parser.
//
// Usage: received characters enter on the s_axis channel, one byte per
// transfer. Result items leave on the m_axis channel: a field character with
// its field and character indices, the start of a new field, or the checksum
// verdict at the end of a sentence. Bytes that cause no result leave nothing.
// The user must write the three type code registers on the cfg channel (index
// 0 to 2) only while no sentence is in flight; the block does not enforce it.
// cfg_ready_o is always high. A byte accepted on s_axis is held in the input
// register, decoded by the parser and its result captured in the result
// register, which drives m_axis. Throughput is one byte per cycle while
// the receiver does not stall. Reset puts the parser idle, waiting for a
// dollar, and loads the default type codes. When the receiver stalls, the
// result register holds its item, the byte behind it waits in the input
// register, and s_axis_tready falls only when both registers are full and
// m_axis_tready is low.
module nmea_sentence_field_extractor #(
  parameter int unsigned MAX_FIELDS      = nsfe_pkg::MAX_FIELDS_DEF,
  parameter int unsigned MAX_FIELD_CHARS = nsfe_pkg::MAX_FIELD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Receive byte stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [4:0] field_index, [8:5] char_index,
                                      // [16:9] char_value, [17] checksum_ok, rest zero
  output logic [3:0]  m_axis_tuser,   // [1:0] event_kind, [3:2] sentence_type
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  nsfe_pkg::result_t out_res_q;
  logic              out_ready;
  logic              advance;
  logic              res_valid;
  nsfe_pkg::result_t res;
  logic [31:0]       code_a_q, code_b_q, code_c_q;

  // Pipeline flow control.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_valid_d    = s_axis_tvalid;
  assign out_valid_d   = advance && res_valid;

  // Type code registers.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_a_q <= nsfe_pkg::TYPE_CODE_A_RST;
      code_b_q <= nsfe_pkg::TYPE_CODE_B_RST;
      code_c_q <= nsfe_pkg::TYPE_CODE_C_RST;
    end else if (cfg_valid_i) begin
      unique case (nsfe_pkg::cfg_reg_e'(cfg_index_i))
        nsfe_pkg::CFG_TYPE_A: code_a_q <= cfg_data_i;
        nsfe_pkg::CFG_TYPE_B: code_b_q <= cfg_data_i;
        nsfe_pkg::CFG_TYPE_C: code_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  nsfe_parser #(
    .MAX_FIELDS      (MAX_FIELDS),
    .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .rx_byte_i     (in_byte_q),
    .type_code_a_i (code_a_q),
    .type_code_b_i (code_b_q),
    .type_code_c_i (code_c_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d && out_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_res_q.checksum_ok, out_res_q.char_value,
                          out_res_q.char_index, out_res_q.field_index};
  assign m_axis_tuser  = {out_res_q.sentence_type, out_res_q.event_kind};

endmodule

// ===== tb/sv/tb_nmea_sentence_field_extractor.sv =====
// Self-checking testbench of the sentence field extractor: streams bytes in,
// predicts every result item and compares it on the result stream.
// Depends on nsfe_pkg and the nmea_sentence_field_extractor RTL.
module tb_nmea_sentence_field_extractor;
  import nsfe_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_CAP     = 25;

  // Clock, reset and block ports.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Stimulus and checking bookkeeping.
  logic [7:0]  rx_backlog[$];
  result_t     expected_events[$];
  logic        rx_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_active = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;
  int          mismatch_count = 0;
  int          bytes_accepted = 0;
  int          events_checked = 0;
  int          verdicts_checked = 0;
  int          cfg_writes = 0;
  logic [31:0] stim_code[3];

  // Predicted parser state and type code registers.
  logic [31:0] pred_code[3];
  logic        sent_active = 1'b0;
  int unsigned hdr_cnt = 0;
  logic [31:0] hdr_word = '0;
  logic [1:0]  match_sel = SENT_A;
  logic        fld_open = 1'b0;
  int unsigned fld_num = 0;
  int unsigned chr_pos = 0;
  logic        in_cksum = 1'b0;
  logic [7:0]  run_xor = '0;
  logic [7:0]  hex_first = '0;
  logic        hex_seen = 1'b0;

  nmea_sentence_field_extractor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Value of one checksum character; anything but 0-9 and A-F counts as itself.
  function automatic logic [7:0] hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
    return c;
  endfunction

  // Advance the predicted parser by one accepted byte and store any result.
  function automatic void parse_rx_byte(logic [7:0] b);
    result_t    ev;
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] got;
    ev = '0;
    if (b == CH_DOLLAR) begin
      sent_active = 1'b1;
      hdr_cnt     = 0;
      hdr_word    = '0;
      match_sel   = SENT_A;
      fld_open    = 1'b0;
      fld_num     = 0;
      chr_pos     = 0;
      in_cksum    = 1'b0;
      hex_seen    = 1'b0;
      return;
    end
    if (!sent_active) return;
    if (hdr_cnt < HDR_BODY) hdr_cnt++;
    if (hdr_cnt <= 1) begin
      run_xor = b;
      return;
    end
    if (b == CH_STAR) begin
      hdr_word = '0;
      in_cksum = 1'b1;
      hex_seen = 1'b0;
      return;
    end
    if (!in_cksum) run_xor ^= b;
    if (hdr_cnt < HDR_BODY) begin
      hdr_word[(hdr_cnt - 2) * 8 +: 8] = b;
      return;
    end
    // Checksum capture: two characters, then the verdict ends the sentence.
    if (in_cksum) begin
      if (!hex_seen) begin
        hex_first = b;
        hex_seen  = 1'b1;
        return;
      end
      h0  = hex_value(hex_first);
      h1  = hex_value(b);
      got = {h0[3:0], 4'h0} + h1;
      in_cksum    = 1'b0;
      hex_seen    = 1'b0;
      sent_active = 1'b0;
      ev.event_kind    = EV_VERDICT;
      ev.sentence_type = match_sel;
      ev.checksum_ok   = (got == run_xor);
      expected_events.push_back(ev);
      return;
    end
    // The body is checked against the type codes on every byte; first match wins.
    if (hdr_word == pred_code[CFG_TYPE_A]) match_sel = SENT_A;
    else if (hdr_word == pred_code[CFG_TYPE_B]) match_sel = SENT_B;
    else if (hdr_word == pred_code[CFG_TYPE_C]) match_sel = SENT_C;
    else begin
      sent_active = 1'b0;
      return;
    end
    ev.sentence_type = match_sel;
    if (b == CH_COMMA) begin
      chr_pos = 0;
      if (!fld_open) begin
        fld_open = 1'b1;
        fld_num  = 0;
      end else if (fld_num < MAX_FIELDS_DEF) begin
        fld_num++;
      end
      if (fld_num < MAX_FIELDS_DEF) begin
        ev.event_kind  = EV_FIELD;
        ev.field_index = fld_num[4:0];
        expected_events.push_back(ev);
      end
      return;
    end
    if (!fld_open || fld_num >= MAX_FIELDS_DEF || chr_pos >= MAX_FIELD_CHARS_DEF) return;
    ev.event_kind  = EV_CHAR;
    ev.field_index = fld_num[4:0];
    ev.char_index  = chr_pos[3:0];
    ev.char_value  = b;
    expected_events.push_back(ev);
    chr_pos++;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0d] result mismatch: %s", cycle_count, what);
  endtask

  // Compare the result on the bus with the oldest prediction, field by field.
  task automatic check_event();
    result_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result tuser=%h tdata=%h", m_axis_tuser,
                                m_axis_tdata));
      return;
    end
    want = expected_events.pop_front();
    events_checked++;
    if (want.event_kind == EV_VERDICT) verdicts_checked++;
    if (m_axis_tuser[1:0] !== want.event_kind)
      report_mismatch($sformatf("event_kind %h, want %h", m_axis_tuser[1:0], want.event_kind));
    if (m_axis_tuser[3:2] !== want.sentence_type)
      report_mismatch($sformatf("sentence_type %h, want %h", m_axis_tuser[3:2],
                                want.sentence_type));
    if (m_axis_tdata[4:0] !== want.field_index)
      report_mismatch($sformatf("field_index %0d, want %0d", m_axis_tdata[4:0],
                                want.field_index));
    if (m_axis_tdata[8:5] !== want.char_index)
      report_mismatch($sformatf("char_index %0d, want %0d", m_axis_tdata[8:5],
                                want.char_index));
    if (m_axis_tdata[16:9] !== want.char_value)
      report_mismatch($sformatf("char_value %h, want %h", m_axis_tdata[16:9],
                                want.char_value));
    if (m_axis_tdata[17] !== want.checksum_ok)
      report_mismatch($sformatf("checksum_ok %b, want %b", m_axis_tdata[17],
                                want.checksum_ok));
    if (m_axis_tdata[23:18] !== '0)
      report_mismatch($sformatf("tdata padding %h is not zero", m_axis_tdata[23:18]));
  endtask

  // Monitor: every transfer is seen at the rising edge.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    rx_fire     <= rst_ni && s_axis_tvalid && s_axis_tready;
    cfg_fire    <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_event();
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_accepted++;
        parse_rx_byte(s_axis_tdata);
      end
      if (cfg_valid_i && cfg_ready_o) pred_code[cfg_index_i] = cfg_data_i;
    end
  end

  // Byte driver: holds each byte until its transfer, idles at random between bytes.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || rx_fire) begin
      if (rx_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_backlog.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off.
  always @(negedge clk_i) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  // Long hold-off of the receiver, counted here once it is requested.
  initial begin
    wait (hold_request);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb_nmea_sentence_field_extractor: done, errors");
    $finish;
  end

  task automatic push_rx(logic [7:0] b);
    rx_backlog.push_back(b);
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] n);
    return (n < 10) ? 8'h30 + n : 8'h37 + n;
  endfunction

  // Raw text, framing characters included.
  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) push_rx(s[i]);
  endtask

  // Dollar, body, star and the two checksum digits, right or wrong.
  task automatic queue_framed(string body, bit good);
    logic [7:0] ck;
    ck = body[0];
    push_rx(CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) begin
      push_rx(body[i]);
      if (i > 0) ck ^= body[i];
    end
    if (!good) ck = ~ck;
    push_rx(CH_STAR);
    push_rx(hex_digit(ck[7:4]));
    push_rx(hex_digit(ck[3:0]));
  endtask

  // Field content: mostly printable text, sometimes any byte but a dollar.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(99) < 85) begin
      do c = 8'($urandom_range(8'h7E, 8'h20));
      while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
    end else begin
      do c = 8'($urandom_range(255, 0));
      while (c == CH_DOLLAR);
    end
    return c;
  endfunction

  function automatic logic [31:0] random_code();
    logic [31:0] v;
    if ($urandom_range(1)) return $urandom;
    for (int i = 0; i < 4; i++) v[i * 8 +: 8] = 8'($urandom_range(8'h5A, 8'h41));
    return v;
  endfunction

  // One sentence with random content; a minority is broken in various ways.
  task automatic queue_random_sentence();
    int          sel;
    int          nf;
    int          flen;
    logic [31:0] hdr;
    logic [7:0]  ck;
    logic [7:0]  c;
    sel = $urandom_range(99);
    hdr = stim_code[$urandom_range(2)];
    if (sel < 10) hdr = $urandom;
    else if (sel < 15) hdr[$urandom_range(31)] ^= 1'b1;
    push_rx(CH_DOLLAR);
    c = ($urandom_range(3) == 0) ? field_char() : 8'h47;
    ck = c;
    push_rx(c);
    for (int i = 0; i < 4; i++) begin
      c = hdr[i * 8 +: 8];
      push_rx(c);
      ck ^= c;
    end
    // Verdict straight after the header, before any type check.
    if (sel >= 15 && sel < 20) begin
      push_rx(CH_STAR);
      push_rx(hex_digit(ck[7:4]));
      push_rx(hex_digit(ck[3:0]));
      return;
    end
    if ($urandom_range(9) == 0) begin
      c = field_char();
      push_rx(c);
      ck ^= c;
    end
    nf = ($urandom_range(19) == 0) ? $urandom_range(35, 33) : $urandom_range(5, 0);
    for (int f = 0; f < nf; f++) begin
      push_rx(CH_COMMA);
      ck ^= CH_COMMA;
      flen = ($urandom_range(14) == 0) ? $urandom_range(18, 15) : $urandom_range(4, 0);
      for (int j = 0; j < flen; j++) begin
        c = field_char();
        push_rx(c);
        ck ^= c;
      end
    end
    // Truncated sentence: the next dollar cuts it off.
    if (sel >= 20 && sel < 25) return;
    push_rx(CH_STAR);
    if (sel < 85) begin
      push_rx(hex_digit(ck[7:4]));
      push_rx(hex_digit(ck[3:0]));
    end else if (sel < 93) begin
      ck ^= 8'($urandom_range(255, 1));
      push_rx(hex_digit(ck[7:4]));
      push_rx(hex_digit(ck[3:0]));
    end else begin
      for (int i = 0; i < 2; i++) begin
        do c = 8'($urandom_range(255, 0));
        while (c == CH_DOLLAR);
        push_rx(c);
      end
    end
  endtask

  task automatic write_type_code(cfg_reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(negedge clk_i);
    while (!cfg_fire);
    cfg_valid_i = 1'b0;
    stim_code[idx] = value;
    cfg_writes++;
  endtask

  task automatic write_all_codes(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    write_type_code(CFG_TYPE_A, a);
    write_type_code(CFG_TYPE_B, b);
    write_type_code(CFG_TYPE_C, c);
  endtask

  // Random sentences with noise between them, closed by a sentence that
  // always ends in a verdict, so the parser is idle for the next register write.
  task automatic run_phase(int send_pct, int recv_pct, int n_bytes);
    int start;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    start = bytes_accepted + rx_backlog.size();
    while (bytes_accepted + rx_backlog.size() - start < n_bytes) begin
      if ($urandom_range(9) < 3) begin
        repeat ($urandom_range(3, 1)) push_rx(8'($urandom_range(255, 0)));
      end
      queue_random_sentence();
    end
    queue_text("$GTEST*00");
    while (rx_backlog.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Main sequence: reset, directed bytes, then phases of idling and codes.
  initial begin
    logic [31:0] dup;
    stim_code[CFG_TYPE_A] = TYPE_CODE_A_RST;
    stim_code[CFG_TYPE_B] = TYPE_CODE_B_RST;
    stim_code[CFG_TYPE_C] = TYPE_CODE_C_RST;
    pred_code = stim_code;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Stray bytes while idle, a character before the first comma and an empty
    // last field, then a star as first character, a repeated star with a
    // non-hex digit, and a star inside the header.
    push_rx(8'hFF);
    push_rx(8'h00);
    queue_framed("GNRMCx,AB,", 1'b1);
    queue_text("$*NGGA,Q*1*G7");
    queue_text("$GN*RMC5A");
    run_phase(0, 0, 110);

    write_all_codes(32'h0000_0000, 32'hFFFF_FFFF, random_code());
    run_phase(53, 0, 120);

    // All three codes equal: the first one must win.
    dup = random_code();
    write_all_codes(dup, dup, dup);
    run_phase(0, 53, 120);

    write_all_codes(random_code(), random_code(), random_code());
    hold_request = 1'b1;
    run_phase(16, 16, 120);

    write_all_codes(TYPE_CODE_A_RST, TYPE_CODE_B_RST, TYPE_CODE_C_RST);
    run_phase(0, 0, 120);

    $display("covered %0d bytes in five idling phases with %0d code register writes",
             bytes_accepted, cfg_writes);
    $display("checked %0d result items, %0d of them checksum verdicts, %0d mismatches",
             events_checked, verdicts_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_nmea_sentence_field_extractor: done, clean");
    end else begin
      $display("tb_nmea_sentence_field_extractor: done, errors");
    end
    $finish;
  end

endmodule
